FILE: hdl/sabd_pkg.sv
`default_nettype none
package sabd_pkg;

    // History and CORDIC sizing
    localparam int HISTORY_DEPTH = 3;
    localparam int CORDIC_STEPS  = 20;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);

    // Data widths
    localparam int DATA_W   = 64;
    localparam int ANGLE_W  = 19;
    localparam int LIMIT_W  = 19;
    localparam int XY_W     = 34;
    localparam int Z_W      = 27;
    localparam int ATAN_W   = 24;
    localparam int IN_W     = 128;
    localparam int OUT_W    = 24;

    // Angle constants
    localparam logic [17:0] PI_Q16      = 18'd205887;
    localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
    localparam logic [24:0] HALF_PI_Q24 = 25'd26353589;

    // Register indexes
    localparam logic [0:0] REG_MAX_ANGLE     = 1'b0;
    localparam logic [0:0] REG_INITIAL_LEVEL = 1'b1;

    // atan(2^-i) in Q.24, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q24(input logic [4:0] idx);
        logic [ATAN_W-1:0] r;
        case (idx)
            5'd0:    r = 24'd13176795;
            5'd1:    r = 24'd7778716;
            5'd2:    r = 24'd4110060;
            5'd3:    r = 24'd2086331;
            5'd4:    r = 24'd1047214;
            5'd5:    r = 24'd524117;
            5'd6:    r = 24'd262123;
            5'd7:    r = 24'd131069;
            5'd8:    r = 24'd65536;
            5'd9:    r = 24'd32768;
            5'd10:   r = 24'd16384;
            5'd11:   r = 24'd8192;
            5'd12:   r = 24'd4096;
            5'd13:   r = 24'd2048;
            5'd14:   r = 24'd1024;
            5'd15:   r = 24'd512;
            5'd16:   r = 24'd256;
            5'd17:   r = 24'd128;
            5'd18:   r = 24'd64;
            5'd19:   r = 24'd32;
            5'd20:   r = 24'd16;
            5'd21:   r = 24'd8;
            5'd22:   r = 24'd4;
            5'd23:   r = 24'd2;
            5'd24:   r = 24'd1;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/slope_angle_break_detector.sv
// Channel  Dir  Width  Contents
// s_*      in   128    tdata: sample_value [63:0], sample_time [127:64]
// m_*      out  24     tdata: is_break [0], slope_angle [19:1], zero pad [23:20]
// cfg_*    in   1/64   write enable, register index, write data
//
// An item passes from accept through the slot, difference, normalize, rotation,
// quadrant and output states; the normalizer shifts by 8 or 1 bit per pass, and
// an item with both differences zero skips the rotation.
// The whole sequence, with its CORDIC_STEPS rotation iterations, sets the rate.
// s_tready is high only while the sequencer is idle, at the earliest in the cycle
// after a result is loaded.
// A result waits in the output register; a stalled m_tready holds the next
// result in the final state until the output register frees.
// Reset (rst_n low, asynchronous) clears histories and all but the working registers.
`default_nettype none
module slope_angle_break_detector (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sabd_pkg::IN_W-1:0]     s_tdata,   // sample_value, sample_time
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sabd_pkg::OUT_W-1:0]         m_tdata,   // is_break, slope_angle, pad
    input  wire logic                          cfg_wen,
    input  wire logic [0:0]                    cfg_addr,
    input  wire logic [sabd_pkg::DATA_W-1:0]   cfg_wdata
);

    localparam int DW  = sabd_pkg::DATA_W;
    localparam int SW  = sabd_pkg::SLOT_W;
    localparam int XW  = sabd_pkg::XY_W;
    localparam int ZW  = sabd_pkg::Z_W;
    localparam int AW  = sabd_pkg::ANGLE_W;
    localparam int HD  = sabd_pkg::HISTORY_DEPTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLOT = 3'd1;
    localparam logic [2:0] S_DX   = 3'd2;
    localparam logic [2:0] S_DT   = 3'd3;
    localparam logic [2:0] S_NORM = 3'd4;
    localparam logic [2:0] S_ROT  = 3'd5;
    localparam logic [2:0] S_QUAD = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [SW-1:0] LAST_SLOT = SW'(HD - 1);
    localparam logic [sabd_pkg::STEP_W-1:0] LAST_STEP =
        sabd_pkg::STEP_W'(sabd_pkg::CORDIC_STEPS - 1);

    // History stores
    logic [DW-1:0]  value_hist_reg [HD];
    logic [DW-1:0]  time_hist_reg  [HD];
    logic [AW-1:0]  angle_hist_reg [HD];

    // Control and working registers
    logic [2:0]                   state_reg, state_next;
    logic [SW-1:0]                slot_reg, slot_next;
    logic [SW-1:0]                rd_idx_reg, rd_idx_next;
    logic [sabd_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [DW-1:0]                v_reg, v_next;
    logic [DW-1:0]                t_reg, t_next;
    logic [DW-1:0]                mx_reg, mx_next;
    logic [DW-1:0]                my_reg, my_next;
    logic                         dx_neg_reg, dx_neg_next;
    logic                         dt_neg_reg, dt_neg_next;
    logic [AW-1:0]                prev_ang_reg, prev_ang_next;
    logic signed [XW-1:0]         x_reg, x_next;
    logic signed [XW-1:0]         y_reg, y_next;
    logic signed [ZW-1:0]         z_reg, z_next;
    logic [16:0]                  q_reg, q_next;
    logic [AW-1:0]                ang_reg, ang_next;
    logic                         ang_pend_reg;
    logic [sabd_pkg::LIMIT_W-1:0] max_angle_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [sabd_pkg::OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    // History write controls
    logic            hist_we;
    logic [SW-1:0]   hist_widx;

    // Datapath helpers
    logic [DW-1:0]         rd_value;
    logic [DW-1:0]         rd_time;
    logic [AW-1:0]         rd_angle;
    logic [SW-1:0]         cur_sel;
    logic [DW-1:0]         mag_or;
    logic signed [XW-1:0]  x_sh;
    logic signed [XW-1:0]  y_sh;
    logic signed [ZW-1:0]  atan_step;
    logic [24:0]           z_clamp;
    logic [25:0]           z_round;
    logic [17:0]           q_full;
    logic [17:0]           quad_mag;
    logic [AW-1:0]         quad_ext;
    logic [AW-1:0]         ang_val;
    logic signed [AW:0]    ang_diff;
    logic [AW:0]           ang_abs;
    logic                  s_accept;
    logic                  out_free;

    assign rd_value = value_hist_reg[rd_idx_reg];
    assign rd_time  = time_hist_reg[rd_idx_reg];
    assign rd_angle = angle_hist_reg[rd_idx_reg];
    assign mag_or   = mx_reg | my_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Shared rotation operands
    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign atan_step = $signed({{(ZW - sabd_pkg::ATAN_W){1'b0}},
                                sabd_pkg::atan_q24(5'(step_reg))});

    // Clamp and round the Q.24 angle to Q.16
    always_comb
    begin
        if (z_reg < 0)
            z_clamp = 25'd0;
        else if (z_reg > $signed({2'b00, sabd_pkg::HALF_PI_Q24}))
            z_clamp = sabd_pkg::HALF_PI_Q24;
        else
            z_clamp = z_reg[24:0];
        z_round = {1'b0, z_clamp} + 26'd128;
        q_full  = z_round[25:8];
    end

    // Quadrant mapping
    assign quad_mag = dt_neg_reg ? (sabd_pkg::PI_Q16 - {1'b0, q_reg}) : {1'b0, q_reg};
    assign quad_ext = {1'b0, quad_mag};
    assign ang_val  = dx_neg_reg ? AW'(0) - quad_ext : quad_ext;

    // Angle change against the previous slot
    assign ang_diff = $signed({ang_reg[AW-1], ang_reg}) -
                      $signed({prev_ang_reg[AW-1], prev_ang_reg});
    assign ang_abs  = ang_diff[AW] ? (AW+1)'(0) - ang_diff : ang_diff;

    // Slot chosen for the incoming item
    assign cur_sel = (t_reg > rd_time)
                   ? ((slot_reg == LAST_SLOT) ? SW'(0) : slot_reg + SW'(1))
                   : slot_reg;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        rd_idx_next   = rd_idx_reg;
        step_next     = step_reg;
        v_next        = v_reg;
        t_next        = t_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        dx_neg_next   = dx_neg_reg;
        dt_neg_next   = dt_neg_reg;
        prev_ang_next = prev_ang_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        q_next        = q_reg;
        ang_next      = ang_pend_reg ? ang_val : ang_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        hist_we       = 1'b0;
        hist_widx     = cur_sel;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    v_next      = s_tdata[DW-1:0];
                    t_next      = s_tdata[2*DW-1:DW];
                    rd_idx_next = slot_reg;
                    state_next  = S_SLOT;
                end
            end
            // Advance or overwrite, store the sample, point at the previous slot
            S_SLOT:
            begin
                slot_next   = cur_sel;
                hist_we     = 1'b1;
                rd_idx_next = (cur_sel == SW'(0)) ? LAST_SLOT : cur_sel - SW'(1);
                state_next  = S_DX;
            end
            S_DX:
            begin
                dx_neg_next   = $signed(v_reg) < $signed(rd_value);
                my_next       = dx_neg_next ? rd_value - v_reg : v_reg - rd_value;
                prev_ang_next = rd_angle;
                state_next    = S_DT;
            end
            S_DT:
            begin
                dt_neg_next = t_reg < rd_time;
                mx_next     = dt_neg_next ? rd_time - t_reg : t_reg - rd_time;
                state_next  = S_NORM;
            end
            // Bring the larger magnitude's top bit to bit 29; both zero skips the rotation
            S_NORM:
            begin
                if (mag_or == '0)
                begin
                    z_next     = '0;
                    state_next = S_QUAD;
                end
                else if (|mag_or[DW-1:37])
                begin
                    mx_next = mx_reg >> 8;
                    my_next = my_reg >> 8;
                end
                else if (|mag_or[DW-1:30])
                begin
                    mx_next = mx_reg >> 1;
                    my_next = my_reg >> 1;
                end
                else if (mag_or[DW-1:22] == '0)
                begin
                    mx_next = mx_reg << 8;
                    my_next = my_reg << 8;
                end
                else if (!mag_or[29])
                begin
                    mx_next = mx_reg << 1;
                    my_next = my_reg << 1;
                end
                else
                begin
                    x_next     = $signed({{(XW - 30){1'b0}}, mx_reg[29:0]});
                    y_next     = $signed({{(XW - 30){1'b0}}, my_reg[29:0]});
                    z_next     = '0;
                    step_next  = '0;
                    state_next = S_ROT;
                end
            end
            // One vectoring iteration per cycle
            S_ROT:
            begin
                if (y_reg >= 0)
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_step;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_step;
                end
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_QUAD;
                end
                else
                begin
                    step_next = step_reg + sabd_pkg::STEP_W'(1);
                end
            end
            // Round to Q.16 and clamp to a quarter turn
            S_QUAD:
            begin
                q_next     = (q_full > {1'b0, sabd_pkg::HALF_PI_Q16})
                           ? sabd_pkg::HALF_PI_Q16 : q_full[16:0];
                state_next = S_OUT;
            end
            // Signed angle lands in ang_reg first, then emit once the output register frees
            S_OUT:
            begin
                if (out_free && !ang_pend_reg)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(sabd_pkg::OUT_W - AW - 1){1'b0}}, ang_reg,
                                     (ang_abs > {1'b0, max_angle_reg})};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, histories and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            rd_idx_reg    <= '0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            max_angle_reg <= '0;
            ang_pend_reg  <= 1'b0;
            for (int i = 0; i < HD; i++)
            begin
                value_hist_reg[i] <= '0;
                time_hist_reg[i]  <= '0;
                angle_hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            rd_idx_reg   <= rd_idx_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            ang_pend_reg <= (state_reg == S_QUAD);

            // Store the sample in the chosen slot
            if (hist_we)
            begin
                value_hist_reg[hist_widx] <= v_reg;
                time_hist_reg[hist_widx]  <= t_reg;
            end

            // Record the new angle as soon as it is known
            if (ang_pend_reg)
                angle_hist_reg[slot_reg] <= ang_val;

            // Register writes; a level write reloads the history
            if (cfg_wen)
            begin
                unique case (cfg_addr)
                    sabd_pkg::REG_MAX_ANGLE:
                    begin
                        max_angle_reg <= cfg_wdata[sabd_pkg::LIMIT_W-1:0];
                    end
                    sabd_pkg::REG_INITIAL_LEVEL:
                    begin
                        slot_reg <= '0;
                        for (int i = 0; i < HD; i++)
                        begin
                            value_hist_reg[i] <= cfg_wdata;
                            time_hist_reg[i]  <= '0;
                            angle_hist_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        t_reg        <= t_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        dx_neg_reg   <= dx_neg_next;
        dt_neg_reg   <= dt_neg_next;
        prev_ang_reg <= prev_ang_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        q_reg        <= q_next;
        ang_reg      <= ang_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Slot index stays inside the history
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot index beyond history depth");

    // The x component never goes negative during rotation
    a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> !x_reg[XW-1])
        else $error("CORDIC x went negative");

    // Step counter idles at zero outside the rotation loop
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ROT) |-> (step_reg == '0))
        else $error("step counter left running");

    // Rounded magnitude never exceeds a quarter turn
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (q_reg <= sabd_pkg::HALF_PI_Q16))
        else $error("rounded angle out of range");

    // An accepted item leaves the idle state at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == S_SLOT))
        else $error("accepted item did not start");

endmodule
`default_nettype wire
